[rtl/msfs_pkg.sv]
// Shared constants and types for the minor frame schedule table.
package msfs_pkg;

  localparam int NUM_FRAMES      = 8;
  localparam int FRAME_W         = 3;
  localparam int SLOTS_PER_FRAME = 32;
  localparam int MSG_ID_WIDTH    = 8;
  localparam int IDX_W           = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
  localparam int CNT_W           = $clog2(SLOTS_PER_FRAME + 1);

  localparam int FRAC_STEP = 8;
  localparam int FRAC_MOD  = 50;
  localparam int SEC_MOD   = 60;
  localparam int MIN_MOD   = 60;
  localparam int HOUR_WRAP = 255;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD_OK  = 2'd0,
    KIND_ADD_OVF = 2'd1,
    KIND_MSG     = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic             acc_add;
    logic             acc_run;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] rd_idx;
  } msfs_cmd_t;

  typedef struct packed {
    logic             can_load;
    logic             in_empty;
    logic [CNT_W-1:0] run_cnt;
  } msfs_sts_t;

endpackage

[rtl/msfs_in_if.sv]
// Input item channel: operation request with valid/ready handshake.
interface msfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] msg_id;
  logic [2:0] phase;
  logic [1:0] rate_code;
  logic [2:0] frame;

  modport source(output valid, output op, output msg_id, output phase,
                 output rate_code, output frame, input ready);
  modport sink(input valid, input op, input msg_id, input phase,
               input rate_code, input frame, output ready);
endinterface

[rtl/msfs_out_if.sv]
// Result item channel: status or scheduled message with time broadcast words.
interface msfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  frame_out;
  logic [7:0]  msg_out;
  logic [15:0] time_high;
  logic [15:0] time_low;
  logic        last;

  modport source(output valid, output kind, output frame_out, output msg_out,
                 output time_high, output time_low, output last, input ready);
  modport sink(input valid, input kind, input frame_out, input msg_out,
               input time_high, input time_low, input last, output ready);
endinterface

[rtl/msfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module msfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/msfs_dp.sv]
// Datapath: frame RAMs, fill counts, time broadcast clock and result register.
module msfs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msfs_pkg::msfs_cmd_t           cmd,
  output msfs_pkg::msfs_sts_t           sts,
  input  logic [7:0]                    in_msg_id,
  input  logic [2:0]                    in_phase,
  input  logic [1:0]                    in_rate_code,
  input  logic [msfs_pkg::FRAME_W-1:0]  in_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [2:0]                    out_frame,
  output logic [7:0]                    out_msg,
  output logic [15:0]                   out_time_high,
  output logic [15:0]                   out_time_low,
  output logic                          out_last
);

  localparam int NF  = msfs_pkg::NUM_FRAMES;
  localparam int FW  = msfs_pkg::FRAME_W;
  localparam int IW  = msfs_pkg::IDX_W;
  localparam int CW  = msfs_pkg::CNT_W;
  localparam int MW  = msfs_pkg::MSG_ID_WIDTH;

  logic [CW-1:0] counts_r [NF];
  logic [NF-1:0] hit;
  logic [NF-1:0] full_vec;
  logic          full_any;
  logic [NF-1:0] we;
  logic [MW-1:0] id_w;
  logic [MW-1:0] rdata [NF];

  logic [7:0] hours_r, hours_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] frac_r, frac_nxt;
  logic [6:0] frac_sum;
  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [7:0] hour_inc;
  logic       adv;

  logic [FW-1:0] run_frame_r;
  logic [CW-1:0] run_cnt_r;

  logic          out_valid_r;
  logic [1:0]    kind_r, kind_nxt;
  logic [2:0]    frame_out_r, frame_out_nxt;
  logic [7:0]    msg_r, msg_nxt;
  logic [15:0]   th_r;
  logic [15:0]   tl_r;
  logic          last_r, last_nxt;
  logic          load;
  logic [2:0]    low_mask;

  assign id_w     = MW'(in_msg_id);
  assign low_mask = 3'((4'd8 >> in_rate_code) - 4'd1);

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      hit[f]      = ((3'(f) - in_phase) & low_mask) == 3'd0;
      full_vec[f] = counts_r[f] >= CW'(msfs_pkg::SLOTS_PER_FRAME);
    end
  end

  assign full_any = |(hit & full_vec);
  assign we       = (cmd.acc_add && !full_any) ? hit : '0;

  for (genvar g = 0; g < NF; g++) begin : g_frame
    msfs_ram #(
      .WIDTH(MW),
      .DEPTH(msfs_pkg::SLOTS_PER_FRAME)
    ) u_ram (
      .clk  (clk),
      .we   (we[g]),
      .waddr(counts_r[g][IW-1:0]),
      .wdata(id_w),
      .raddr(cmd.rd_idx),
      .rdata(rdata[g])
    );
  end

  // time broadcast clock, advanced on every run of frame zero
  assign adv = cmd.acc_run && (in_frame == '0);

  always_comb begin
    frac_sum = 7'(frac_r) + 7'(msfs_pkg::FRAC_STEP);
    sec_inc  = 7'(sec_r) + 7'd1;
    min_inc  = 7'(min_r) + 7'd1;
    hour_inc = hours_r + 8'd1;
    hours_nxt = hours_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    if (adv) begin
      frac_nxt = 6'(frac_sum);
      if (frac_sum >= 7'(msfs_pkg::FRAC_MOD)) begin
        frac_nxt = 6'(frac_sum - 7'(msfs_pkg::FRAC_MOD));
        sec_nxt  = 6'(sec_inc);
        if (sec_inc >= 7'(msfs_pkg::SEC_MOD)) begin
          sec_nxt = '0;
          min_nxt = 6'(min_inc);
          if (min_inc >= 7'(msfs_pkg::MIN_MOD)) begin
            min_nxt   = '0;
            hours_nxt = (hour_inc == 8'(msfs_pkg::HOUR_WRAP)) ? 8'd0 : hour_inc;
          end
        end
      end
    end
  end

  always_comb begin
    kind_nxt      = kind_r;
    frame_out_nxt = frame_out_r;
    msg_nxt       = msg_r;
    last_nxt      = last_r;
    load          = 1'b0;
    if (cmd.acc_add) begin
      load          = 1'b1;
      kind_nxt      = full_any ? msfs_pkg::KIND_ADD_OVF : msfs_pkg::KIND_ADD_OK;
      frame_out_nxt = in_phase;
      msg_nxt       = 8'(id_w);
      last_nxt      = 1'b1;
    end else if (cmd.acc_run && sts.in_empty) begin
      load          = 1'b1;
      kind_nxt      = msfs_pkg::KIND_EMPTY;
      frame_out_nxt = 3'(in_frame);
      msg_nxt       = '0;
      last_nxt      = 1'b1;
    end else if (cmd.emit) begin
      load          = 1'b1;
      kind_nxt      = msfs_pkg::KIND_MSG;
      frame_out_nxt = 3'(run_frame_r);
      msg_nxt       = 8'(rdata[run_frame_r]);
      last_nxt      = cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NF; f++) begin
        counts_r[f] <= '0;
      end
      hours_r     <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int f = 0; f < NF; f++) begin
        if (we[f]) begin
          counts_r[f] <= counts_r[f] + CW'(1);
        end
      end
      hours_r <= hours_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_run) begin
      run_frame_r <= in_frame;
      run_cnt_r   <= counts_r[in_frame];
    end
    if (load) begin
      kind_r      <= kind_nxt;
      frame_out_r <= frame_out_nxt;
      msg_r       <= msg_nxt;
      last_r      <= last_nxt;
      th_r        <= {hours_nxt, 2'b00, min_nxt};
      tl_r        <= {2'b00, sec_nxt, 2'b00, frac_nxt};
    end
  end

  assign sts.can_load = !out_valid_r || out_ready;
  assign sts.in_empty = counts_r[in_frame] == '0;
  assign sts.run_cnt  = run_cnt_r;

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_frame     = frame_out_r;
  assign out_msg       = msg_r;
  assign out_time_high = th_r;
  assign out_time_low  = tl_r;
  assign out_last      = last_r;

endmodule

[rtl/msfs_ctrl.sv]
// Controller: input handshake and the sequencer that walks a frame's slots.
module msfs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  output msfs_pkg::msfs_cmd_t  cmd,
  input  msfs_pkg::msfs_sts_t  sts
);

  localparam int IW = msfs_pkg::IDX_W;
  localparam int CW = msfs_pkg::CNT_W;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          acc;

  assign in_ready = (state_r == S_IDLE) && sts.can_load;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd.acc_add   = acc && (in_op == msfs_pkg::OP_ADD);
    cmd.acc_run   = acc && (in_op == msfs_pkg::OP_RUN);
    cmd.emit      = (state_r == S_EMIT) && sts.can_load;
    cmd.emit_last = (CW'(idx_r) + CW'(1)) == sts.run_cnt;
    cmd.rd_idx    = '0;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (cmd.acc_run && !sts.in_empty) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // read address runs one ahead so the RAM output tracks idx_r
        cmd.rd_idx = cmd.emit ? IW'(idx_r + IW'(1)) : idx_r;
        if (cmd.emit) begin
          idx_nxt = IW'(idx_r + IW'(1));
          if (cmd.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[rtl/minor_frame_schedule_table.sv]
// Top level of the minor frame schedule table.
// Usage:
//   in_if carries one request per item: op 0 adds msg_id to 1, 2, 4 or 8 of
//   the 8 minor frames (starting at phase, evenly spaced), op 1 runs frame.
//   out_if returns results: one add status per add, or per run the frame's
//   ids in insertion order with last on the final one, or one empty marker.
//   Running frame 0 advances the time broadcast clock before its results;
//   every result carries the current time words.
// Timing:
//   An add with no full target frame writes all target frames in the accept
//   cycle; its status is registered and shows in the next cycle, as does
//   a run's empty marker. A run's ids pass the registered RAM read and the
//   result register, one id per cycle while the receiver does not stall.
//   The next item is accepted once the run's last id is registered.
// Reset (rst_n low, synchronous) clears all frame counts, the clock and the
// result valid flag; the frame RAMs and the result data are not cleared.
// A stalled receiver holds the result register; the sequencer and input wait.
module minor_frame_schedule_table (
  input  logic             clk,
  input  logic             rst_n,
  msfs_in_if.sink          in_if,
  msfs_out_if.source       out_if
);

  msfs_pkg::msfs_cmd_t cmd;
  msfs_pkg::msfs_sts_t sts;
  logic                in_ready;

  assign in_if.ready = in_ready;

  msfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_op   (in_if.op),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  msfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_msg_id    (in_if.msg_id),
    .in_phase     (in_if.phase),
    .in_rate_code (in_if.rate_code),
    .in_frame     (in_if.frame),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_kind     (out_if.kind),
    .out_frame    (out_if.frame_out),
    .out_msg      (out_if.msg_out),
    .out_time_high(out_if.time_high),
    .out_time_low (out_if.time_low),
    .out_last     (out_if.last)
  );

endmodule

[rtl/msfs_chk.sv]
// Port-level checker for the minor frame schedule table, bound to the top.
module msfs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic [7:0]  in_msg_id,
  input logic [2:0]  in_phase,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_frame,
  input logic [7:0]  out_msg,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken with no room for its result");

  a_add_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == msfs_pkg::OP_ADD) |=>
      out_valid && out_last && out_frame == $past(in_phase)
      && out_msg == $past(in_msg_id)
      && (out_kind == msfs_pkg::KIND_ADD_OK || out_kind == msfs_pkg::KIND_ADD_OVF))
    else $error("add status missing or wrong");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == msfs_pkg::KIND_EMPTY |-> out_last && out_msg == 8'd0)
    else $error("empty marker malformed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == msfs_pkg::KIND_ADD_OK || out_kind == msfs_pkg::KIND_ADD_OVF)
      |-> out_last)
    else $error("add status without last");

endmodule

bind minor_frame_schedule_table msfs_chk u_msfs_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .in_op    (in_if.op),
  .in_msg_id(in_if.msg_id),
  .in_phase (in_if.phase),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_kind (out_if.kind),
  .out_frame(out_if.frame_out),
  .out_msg  (out_if.msg_out),
  .out_last (out_if.last)
);

[verif/tb.sv]
// Self-checking testbench for the minor frame schedule table (directed + random traffic).
`timescale 1ns / 100ps

module tb;
  import msfs_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_WAIT  = 2 * SLOTS_PER_FRAME + 8;

  typedef struct packed {
    logic       op;
    logic [7:0] msg_id;
    logic [2:0] phase;
    logic [1:0] rate_code;
    logic [2:0] frame;
  } sched_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  frame;
    logic [7:0]  msg;
    logic [15:0] time_high;
    logic [15:0] time_low;
    logic        last;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n;

  msfs_in_if  in_if();
  msfs_out_if out_if();

  minor_frame_schedule_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // schedule and time broadcast state as the block should hold it
  logic [7:0]    frame_ids [NUM_FRAMES][SLOTS_PER_FRAME];
  int            frame_fill [NUM_FRAMES];
  int            bc_hours, bc_minutes, bc_seconds, bc_fraction;
  sched_result_t pending_results[$];

  int err_count     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] time_high_word();
    return 16'((bc_hours << 8) | bc_minutes);
  endfunction

  function automatic logic [15:0] time_low_word();
    return 16'((bc_seconds << 8) | bc_fraction);
  endfunction

  task automatic advance_broadcast_clock();
    bc_fraction = bc_fraction + FRAC_STEP;
    if (bc_fraction >= FRAC_MOD) begin
      bc_fraction = bc_fraction % FRAC_MOD;
      bc_seconds++;
      if (bc_seconds >= SEC_MOD) begin
        bc_seconds = 0;
        bc_minutes++;
        if (bc_minutes >= MIN_MOD) begin
          bc_minutes = 0;
          bc_hours++;
          if (bc_hours == HOUR_WRAP) bc_hours = 0;
        end
      end
    end
  endtask

  task automatic push_result(input kind_t kind, input logic [2:0] frame,
                             input logic [7:0] msg, input logic last);
    sched_result_t r;
    r.kind      = kind;
    r.frame     = frame;
    r.msg       = msg;
    r.time_high = time_high_word();
    r.time_low  = time_low_word();
    r.last      = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_schedule(input sched_req_t r);
    int  copies;
    int  stride;
    int  tgt;
    int  n;
    bit  full;
    if (r.op == OP_ADD) begin
      copies = 1 << r.rate_code;
      stride = NUM_FRAMES / copies;
      full   = 1'b0;
      for (int i = 0; i < copies; i++) begin
        tgt = (r.phase + i * stride) % NUM_FRAMES;
        if (frame_fill[tgt] >= SLOTS_PER_FRAME) full = 1'b1;
      end
      if (!full) begin
        for (int i = 0; i < copies; i++) begin
          tgt = (r.phase + i * stride) % NUM_FRAMES;
          frame_ids[tgt][frame_fill[tgt]] = r.msg_id;
          frame_fill[tgt]++;
        end
      end
      push_result(full ? KIND_ADD_OVF : KIND_ADD_OK, r.phase, r.msg_id, 1'b1);
    end else begin
      if (r.frame == 0) advance_broadcast_clock();
      n = frame_fill[r.frame];
      if (n == 0) begin
        push_result(KIND_EMPTY, r.frame, 8'h00, 1'b1);
      end else begin
        for (int j = 0; j < n; j++)
          push_result(KIND_MSG, r.frame, frame_ids[r.frame][j], j == n - 1);
      end
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected item kind=%0d frame=%0d msg=%0d",
                             out_if.kind, out_if.frame_out, out_if.msg_out));
      end else begin
        want = pending_results.pop_front();
        if (out_if.kind !== want.kind || out_if.frame_out !== want.frame ||
            out_if.msg_out !== want.msg || out_if.time_high !== want.time_high ||
            out_if.time_low !== want.time_low || out_if.last !== want.last)
          note_error($sformatf(
            "exp k=%0d f=%0d m=%0d th=%h tl=%h l=%0d / got k=%0d f=%0d m=%0d th=%h tl=%h l=%0d",
            want.kind, want.frame, want.msg, want.time_high, want.time_low, want.last,
            out_if.kind, out_if.frame_out, out_if.msg_out, out_if.time_high,
            out_if.time_low, out_if.last));
      end
    end
  end

  function automatic sched_req_t add_req(input logic [7:0] id, input logic [2:0] phase,
                                         input logic [1:0] rate);
    sched_req_t r;
    r.op        = OP_ADD;
    r.msg_id    = id;
    r.phase     = phase;
    r.rate_code = rate;
    r.frame     = 3'($urandom_range(7));
    return r;
  endfunction

  function automatic sched_req_t run_req(input logic [2:0] frame);
    sched_req_t r;
    r.op        = OP_RUN;
    r.msg_id    = 8'($urandom_range(255));
    r.phase     = 3'($urandom_range(7));
    r.rate_code = 2'($urandom_range(3));
    r.frame     = frame;
    return r;
  endfunction

  function automatic sched_req_t random_add();
    return add_req(8'($urandom_range(255)), 3'($urandom_range(7)), 2'($urandom_range(3)));
  endfunction

  // valid stays up after the accept; the next call or idle_input decides
  task automatic send_item(input sched_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= r.op;
    in_if.msg_id    <= r.msg_id;
    in_if.phase     <= r.phase;
    in_if.rate_code <= r.rate_code;
    in_if.frame     <= r.frame;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_schedule(r);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_frames();
    for (int f = 0; f < NUM_FRAMES; f++) send_item(run_req(3'(f)));
  endtask

  // frame 0 runs that carry the fraction into seconds several times
  task automatic test_clock_rollover();
    for (int i = 0; i < 48; i++) send_item(run_req(3'd0));
  endtask

  task automatic test_add_patterns();
    send_item(add_req(8'h00, 3'd0, 2'd0));
    send_item(add_req(8'hFF, 3'd7, 2'd1));
    send_item(add_req(8'hA5, 3'd6, 2'd2));
    send_item(add_req(8'h5A, 3'd5, 2'd3));
    send_item(add_req(8'h3C, 3'd1, 2'd2));
    for (int f = 0; f < NUM_FRAMES; f++) send_item(run_req(3'(f)));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int sel;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(9);
      if (sel < 2) begin
        for (int f = 0; f < NUM_FRAMES; f++) send_item(run_req(3'(f)));
        sent += NUM_FRAMES;
      end else if (sel < 6) begin
        send_item(random_add());
        sent++;
      end else begin
        send_item(run_req(3'($urandom_range(7))));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_left = 200;
    for (int i = 0; i < 24; i++) begin
      if ($urandom_range(1)) send_item(random_add());
      else send_item(run_req(3'($urandom_range(7))));
    end
    wait_drain();
  endtask

  task automatic test_overflow();
    int guard;
    bit all_full;
    guard    = 0;
    all_full = 1'b0;
    while (!all_full && guard < 2 * SLOTS_PER_FRAME) begin
      send_item(add_req(8'($urandom_range(255)), 3'($urandom_range(7)), 2'd3));
      all_full = 1'b1;
      foreach (frame_fill[f]) if (frame_fill[f] < SLOTS_PER_FRAME) all_full = 1'b0;
      guard++;
    end
    for (int rc = 0; rc < 4; rc++) send_item(add_req(8'($urandom_range(255)),
                                                      3'($urandom_range(7)), 2'(rc)));
    for (int f = 0; f < NUM_FRAMES; f++) send_item(run_req(3'(f)));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_ADD;
    in_if.msg_id    = '0;
    in_if.phase     = '0;
    in_if.rate_code = '0;
    in_if.frame     = '0;
    out_if.ready    = 1'b0;
    foreach (frame_fill[f]) frame_fill[f] = 0;
    bc_hours    = 0;
    bc_minutes  = 0;
    bc_seconds  = 0;
    bc_fraction = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 68;
    test_empty_frames();
    test_clock_rollover();
    test_add_patterns();
    test_random_traffic(60);
    wait_drain();

    send_idle_pct = 68;
    recv_idle_pct = 36;
    test_backpressure();
    test_random_traffic(50);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_overflow();
    test_random_traffic(40);

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
